FILE: sv/lfscl_pkg.sv
// Shared types, sizes and helpers for the LED frame store with current limiting.
package lfscl_pkg;

    localparam int STRIPS           = 6;
    localparam int PIXELS_PER_STRIP = 15;
    localparam int PIXEL_COUNT      = STRIPS * PIXELS_PER_STRIP;
    localparam int FULL_LEVEL       = 3 * 255;

    localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_W   = $clog2(PIXEL_COUNT + 1);
    localparam int LEVEL_W = $clog2(PIXEL_COUNT * FULL_LEVEL + 1);
    localparam int TOTAL_W = 17;
    localparam int MAX_W   = 16;
    localparam int FW_W    = 8;
    localparam int LIM_W   = MAX_W + $clog2(FULL_LEVEL + 1);
    localparam int DEN_W   = LEVEL_W + FW_W;
    localparam int CMP_W   = (DEN_W > LIM_W) ? DEN_W : LIM_W;
    localparam int RATIO_W = 16;
    localparam int DIV_CNT_W = $clog2(RATIO_W + 1);

    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(900);
    localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(60);

    localparam logic REG_MAX_CURRENT = 1'b0;
    localparam logic REG_FULL_WHITE  = 1'b1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_CHK,
        ST_DIV,
        ST_SCAN,
        ST_OUT
    } t_state;

    function automatic logic [9:0] pix_level(input t_pixel p);
        return 10'(p.red) + 10'(p.green) + 10'(p.blue);
    endfunction

    function automatic logic [7:0] scale_chan(input logic [7:0] c,
                                              input logic [RATIO_W-1:0] ratio);
        logic [RATIO_W+7:0] prod;
        prod = (RATIO_W+8)'(c) * (RATIO_W+8)'(ratio);
        return prod[RATIO_W+7:RATIO_W];
    endfunction

endpackage

FILE: sv/lfscl_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module lfscl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 90,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/led_frame_store_current_limiter.sv
// Top level: pixel frame store with running level sum and global current limiting.
//
//  channel   direction  handshake              payload
//  s stream  in         i_s_tvalid/o_s_tready  tdata strip,pixel,r,g,b; tuser func
//  m stream  out        o_m_tvalid/i_m_tready  tdata r,g,b,total; tuser was_scaled
//  apb cfg   in         psel/penable/pready    max current, full white current
//
// Each item passes idle (accept), update (registered RAM read) and out; a write also passes
// the limit check, and a write that trips the limit runs the 16-bit ratio divider (one
// quotient bit a cycle) and a scaling walk over all PIXEL_COUNT RAM entries before out.
// Reset clears per-pixel valid bits at once; no clearing pass.
// A new beat is taken in idle even while the previous result is still held.
module led_frame_store_current_limiter
    import lfscl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // strip[2:0] pixel[6:3] red[14:7] green[22:15] blue[30:23]
    input  logic        i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // red[7:0] green[15:8] blue[23:16] total_level[40:24]
    output logic        o_m_tuser,   // was_scaled
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_state                 r_state, n_state;
    logic [MAX_W-1:0]       r_max;
    logic [FW_W-1:0]        r_fw;
    logic [PIXEL_COUNT-1:0] r_valid, n_valid;
    logic                   r_rd_vld;
    logic [LEVEL_W-1:0]     r_sum, n_sum;
    logic                   r_func, n_func;
    logic                   r_inr, n_inr;
    logic [ADDR_W-1:0]      r_k, n_k;
    t_pixel                 r_new, n_new;
    t_pixel                 r_res, n_res;
    logic                   r_res_scaled, n_res_scaled;
    logic [DEN_W-1:0]       r_den, n_den;
    logic [DEN_W-1:0]       r_rem, n_rem;
    logic [RATIO_W-1:0]     r_ratio, n_ratio;
    logic [DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic [CNT_W-1:0]       r_issue, n_issue;
    logic                   r_pa_vld, n_pa_vld;
    logic [ADDR_W-1:0]      r_pa_addr, n_pa_addr;
    logic                   r_pb_vld, n_pb_vld;
    logic [ADDR_W-1:0]      r_pb_addr, n_pb_addr;
    t_pixel                 r_pb_pix, n_pb_pix;
    logic [LEVEL_W-1:0]     r_acc, n_acc;
    logic                   r_m_valid, n_m_valid;
    t_pixel                 r_m_pix, n_m_pix;
    logic [LEVEL_W-1:0]     r_m_sum, n_m_sum;
    logic                   r_m_scaled, n_m_scaled;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    t_pixel                 ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [PIXEL_W-1:0]     ram_q;
    t_pixel                 rd_pix;

    logic [2:0]             in_strip;
    logic [3:0]             in_pixel;
    logic                   in_range;
    logic [ADDR_W-1:0]      in_k;
    logic                   s_accept;
    logic                   cfg_wr;
    logic [DEN_W-1:0]       load;
    logic [LIM_W-1:0]       limit;
    logic [DEN_W:0]         rem2;
    t_pixel                 sc_pix;

    assign in_strip = i_s_tdata[2:0];
    assign in_pixel = i_s_tdata[6:3];
    assign in_range = (int'(in_strip) < STRIPS) && (int'(in_pixel) < PIXELS_PER_STRIP);
    assign in_k     = in_range ?
                      ADDR_W'(int'(in_strip) * PIXELS_PER_STRIP + int'(in_pixel)) : '0;
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_FULL_WHITE) ? 32'(r_fw) : 32'(r_max);

    assign rd_pix = r_rd_vld ? t_pixel'(ram_q) : '0;
    assign load   = DEN_W'(r_sum) * DEN_W'(r_fw);
    assign limit  = LIM_W'(r_max) * LIM_W'(FULL_LEVEL);
    assign rem2   = {r_rem, 1'b0};

    assign sc_pix.red   = scale_chan(rd_pix.red, r_ratio);
    assign sc_pix.green = scale_chan(rd_pix.green, r_ratio);
    assign sc_pix.blue  = scale_chan(rd_pix.blue, r_ratio);

    lfscl_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
            r_fw  <= FW_RESET;
        end else if (cfg_wr) begin
            unique case (i_paddr[2])
                REG_MAX_CURRENT: r_max <= i_pwdata[MAX_W-1:0];
                REG_FULL_WHITE:  r_fw  <= i_pwdata[FW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
            r_pa_vld  <= 1'b0;
            r_pb_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_sum     <= n_sum;
            r_m_valid <= n_m_valid;
            r_pa_vld  <= n_pa_vld;
            r_pb_vld  <= n_pb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld     <= r_valid[ram_raddr];
        r_func       <= n_func;
        r_inr        <= n_inr;
        r_k          <= n_k;
        r_new        <= n_new;
        r_res        <= n_res;
        r_res_scaled <= n_res_scaled;
        r_den        <= n_den;
        r_rem        <= n_rem;
        r_ratio      <= n_ratio;
        r_div_cnt    <= n_div_cnt;
        r_issue      <= n_issue;
        r_pa_addr    <= n_pa_addr;
        r_pb_addr    <= n_pb_addr;
        r_pb_pix     <= n_pb_pix;
        r_acc        <= n_acc;
        r_m_pix      <= n_m_pix;
        r_m_sum      <= n_m_sum;
        r_m_scaled   <= n_m_scaled;
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_sum        = r_sum;
        n_func       = r_func;
        n_inr        = r_inr;
        n_k          = r_k;
        n_new        = r_new;
        n_res        = r_res;
        n_res_scaled = r_res_scaled;
        n_den        = r_den;
        n_rem        = r_rem;
        n_ratio      = r_ratio;
        n_div_cnt    = r_div_cnt;
        n_issue      = r_issue;
        n_pa_vld     = 1'b0;
        n_pa_addr    = r_pa_addr;
        n_pb_vld     = 1'b0;
        n_pb_addr    = r_pb_addr;
        n_pb_pix     = r_pb_pix;
        n_acc        = r_acc;
        n_m_valid    = r_m_valid && !i_m_tready;
        n_m_pix      = r_m_pix;
        n_m_sum      = r_m_sum;
        n_m_scaled   = r_m_scaled;
        ram_we       = 1'b0;
        ram_waddr    = r_k;
        ram_wdata    = r_new;
        ram_raddr    = in_k;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_func         = i_s_tuser;
                    n_inr          = in_range;
                    n_k            = in_k;
                    n_new.red      = i_s_tdata[14:7];
                    n_new.green    = i_s_tdata[22:15];
                    n_new.blue     = i_s_tdata[30:23];
                    n_state        = ST_UPD;
                end
            end
            ST_UPD: begin
                n_res_scaled = 1'b0;
                if (!r_inr) begin
                    n_res   = '0;
                    n_state = ST_OUT;
                end else if (r_func == FUNC_READ) begin
                    n_res   = rd_pix;
                    n_state = ST_OUT;
                end else begin
                    n_sum      = r_sum - LEVEL_W'(pix_level(rd_pix)) +
                                 LEVEL_W'(pix_level(r_new));
                    n_res      = r_new;
                    ram_we     = 1'b1;
                    n_valid[r_k] = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                if (CMP_W'(load) > CMP_W'(limit)) begin
                    n_den     = load;
                    n_rem     = DEN_W'(limit);
                    n_ratio   = '0;
                    n_div_cnt = '0;
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (rem2 >= {1'b0, r_den}) begin
                    n_rem   = DEN_W'(rem2 - {1'b0, r_den});
                    n_ratio = {r_ratio[RATIO_W-2:0], 1'b1};
                end else begin
                    n_rem   = rem2[DEN_W-1:0];
                    n_ratio = {r_ratio[RATIO_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(RATIO_W - 1)) begin
                    n_issue = '0;
                    n_acc   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_raddr = r_issue[ADDR_W-1:0];
                if (int'(r_issue) < PIXEL_COUNT) begin
                    n_pa_vld  = 1'b1;
                    n_pa_addr = r_issue[ADDR_W-1:0];
                    n_issue   = r_issue + 1'b1;
                end
                if (r_pa_vld) begin
                    n_pb_vld  = 1'b1;
                    n_pb_addr = r_pa_addr;
                    n_pb_pix  = sc_pix;
                end
                if (r_pb_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pb_addr;
                    ram_wdata = r_pb_pix;
                    n_valid[r_pb_addr] = 1'b1;
                    n_acc     = r_acc + LEVEL_W'(pix_level(r_pb_pix));
                    if (r_pb_addr == r_k) begin
                        n_res        = r_pb_pix;
                        n_res_scaled = 1'b1;
                    end
                    if (r_pb_addr == ADDR_W'(PIXEL_COUNT - 1)) begin
                        n_sum    = n_acc;
                        n_pa_vld = 1'b0;
                        n_pb_vld = 1'b0;
                        n_state  = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_pix    = r_res;
                    n_m_sum    = r_sum;
                    n_m_scaled = r_res_scaled;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'b0, TOTAL_W'(r_m_sum), r_m_pix.blue, r_m_pix.green, r_m_pix.red};
    assign o_m_tuser  = r_m_scaled;

    a_div_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_scaled_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_res_scaled) |->
        (CMP_W'(DEN_W'(r_sum) * DEN_W'(r_fw)) <= CMP_W'(limit)))
        else $error("store still over the limit after scaling");

    a_scan_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_pb_vld && int'(r_issue) < PIXEL_COUNT) |->
        (r_pb_addr != r_issue[ADDR_W-1:0]))
        else $error("scan writes the entry it reads");

    a_scan_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pb_vld && $past(r_pb_vld)) |-> (r_pb_addr == $past(r_pb_addr) + 1'b1))
        else $error("scan write-back skipped an entry");

endmodule

FILE: dv/led_frame_store_current_limiter_tb.sv
// Testbench for the LED frame store with current limiting: stream traffic, APB setup, checks.
`timescale 1ns / 1ps

module led_frame_store_current_limiter_tb;
    import lfscl_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int SETTLE_CYCLES = 130;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_PCT      = 6;
    localparam int MAX_PRINTS    = 100;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [TOTAL_W-1:0] total;
        logic               scaled;
    } t_px_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        o_m_tvalid;
    logic        m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    // frame model state
    t_pixel            frame_mem [PIXEL_COUNT];
    longint unsigned   level_acc;
    logic [MAX_W-1:0]  lim_ma;
    logic [FW_W-1:0]   white_ma;

    t_px_answer px_answer_q[$];
    int         err_cnt;
    int         cycle_cnt;
    int         rx_hold_cycles;
    bit         idle_on;

    led_frame_store_current_limiter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint unsigned px_level(input t_pixel p);
        return longint'(p.red) + longint'(p.green) + longint'(p.blue);
    endfunction

    // Applies one beat to the frame model and returns the answer it should produce.
    function automatic t_px_answer frame_apply(input logic func, input logic [2:0] strip,
                                               input logic [3:0] pix, input t_pixel px);
        t_px_answer      ans;
        int unsigned     k;
        longint unsigned lim64;
        longint unsigned num;
        longint unsigned den;
        longint unsigned ratio;
        longint unsigned rebuilt;
        ans   = '0;
        lim64 = lim_ma;
        if (strip < STRIPS && pix < PIXELS_PER_STRIP) begin
            k = strip * PIXELS_PER_STRIP + pix;
            if (func == FUNC_WRITE) begin
                level_acc = level_acc - px_level(frame_mem[k]) + px_level(px);
                frame_mem[k] = px;
                if (level_acc * white_ma > lim64 * FULL_LEVEL) begin
                    num = lim64 * FULL_LEVEL * 65536;
                    den = level_acc * white_ma;
                    ratio = num / den;
                    rebuilt = 0;
                    foreach (frame_mem[i]) begin
                        frame_mem[i].red   = 8'((frame_mem[i].red * ratio) >> 16);
                        frame_mem[i].green = 8'((frame_mem[i].green * ratio) >> 16);
                        frame_mem[i].blue  = 8'((frame_mem[i].blue * ratio) >> 16);
                        rebuilt += px_level(frame_mem[i]);
                    end
                    level_acc  = rebuilt;
                    ans.scaled = 1'b1;
                end
            end
            ans.red   = frame_mem[k].red;
            ans.green = frame_mem[k].green;
            ans.blue  = frame_mem[k].blue;
        end
        ans.total = TOTAL_W'(level_acc);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_cnt < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // result side: ready pattern and checking
    initial begin
        t_px_answer want;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && m_tready) begin
                if (px_answer_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = px_answer_q.pop_front();
                    if (o_m_tdata[7:0] !== want.red)
                        report_mismatch("red", o_m_tdata[7:0], want.red);
                    if (o_m_tdata[15:8] !== want.green)
                        report_mismatch("green", o_m_tdata[15:8], want.green);
                    if (o_m_tdata[23:16] !== want.blue)
                        report_mismatch("blue", o_m_tdata[23:16], want.blue);
                    if (o_m_tdata[40:24] !== want.total)
                        report_mismatch("total_level", o_m_tdata[40:24], want.total);
                    if (o_m_tuser !== want.scaled)
                        report_mismatch("was_scaled", o_m_tuser, want.scaled);
                end
            end
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_beat(input logic func, input logic [2:0] strip, input logic [3:0] pix,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel px;
        px = '{blue: b, green: g, red: r};
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, b, g, r, pix, strip};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        px_answer_q.push_back(frame_apply(func, strip, pix, px));
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (px_answer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_MAX_CURRENT)
            lim_ma = value[MAX_W-1:0];
        else
            white_ma = value[FW_W-1:0];
    endtask

    task automatic set_limits(input int unsigned lim, input int unsigned white);
        drain_results();
        apb_write(REG_MAX_CURRENT, lim);
        apb_write(REG_FULL_WHITE, white);
    endtask

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_beat(input int read_pct, input int oor_pct);
        logic       func;
        logic [2:0] strip;
        logic [3:0] pix;
        func = ($urandom_range(0, 99) < read_pct) ? FUNC_READ : FUNC_WRITE;
        if ($urandom_range(0, 99) < oor_pct) begin
            strip = 3'($urandom_range(0, 7));
            pix   = 4'($urandom_range(0, 15));
        end else begin
            strip = 3'($urandom_range(0, STRIPS - 1));
            pix   = 4'($urandom_range(0, PIXELS_PER_STRIP - 1));
        end
        send_beat(func, strip, pix, pick_chan(), pick_chan(), pick_chan());
    endtask

    task automatic test_reset_state();
        send_beat(FUNC_READ, 3'd0, 4'd0, 8'hFF, 8'hFF, 8'hFF);
        send_beat(FUNC_READ, 3'(STRIPS - 1), 4'(PIXELS_PER_STRIP - 1), 8'h00, 8'h00, 8'h00);
        drain_results();
    endtask

    task automatic test_directed_ops();
        send_beat(FUNC_WRITE, 3'd0, 4'd0, 8'd255, 8'd255, 8'd255);
        send_beat(FUNC_WRITE, 3'(STRIPS - 1), 4'(PIXELS_PER_STRIP - 1), 8'd1, 8'd128, 8'd254);
        send_beat(FUNC_WRITE, 3'd6, 4'd0, 8'd10, 8'd20, 8'd30);
        send_beat(FUNC_WRITE, 3'd7, 4'd15, 8'd255, 8'd255, 8'd255);
        send_beat(FUNC_WRITE, 3'd0, 4'd15, 8'd255, 8'd0, 8'd255);
        send_beat(FUNC_READ, 3'd7, 4'd3, 8'd0, 8'd0, 8'd0);
        send_beat(FUNC_READ, 3'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        send_beat(FUNC_WRITE, 3'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        // full white along one strip until the limit trips
        for (int p = 0; p < PIXELS_PER_STRIP; p++)
            send_beat(FUNC_WRITE, 3'd1, 4'(p), 8'd255, 8'd255, 8'd255);
        send_beat(FUNC_READ, 3'd1, 4'd0, 8'd0, 8'd0, 8'd0);
        drain_results();
    endtask

    task automatic test_zero_full_white();
        set_limits(900, 0);
        for (int n = 0; n < 30; n++)
            send_beat(FUNC_WRITE, 3'(n % STRIPS), 4'(n % PIXELS_PER_STRIP),
                      8'd255, 8'd255, 8'd255);
        drain_results();
    endtask

    task automatic test_zero_limit();
        set_limits(0, 60);
        send_beat(FUNC_WRITE, 3'd2, 4'd7, 8'd0, 8'd0, 8'd0);
        send_beat(FUNC_WRITE, 3'd2, 4'd7, 8'd1, 8'd0, 8'd0);
        send_beat(FUNC_READ, 3'd0, 4'd0, 8'd0, 8'd0, 8'd0);
        send_beat(FUNC_WRITE, 3'd4, 4'd9, 8'd200, 8'd100, 8'd50);
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned lim, input int unsigned white,
                                       input int beats, input bit with_idle);
        set_limits(lim, white);
        idle_on = with_idle;
        for (int n = 0; n < beats; n++)
            send_random_beat(15, 8);
        drain_results();
        idle_on = 1'b1;
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_output_stall();
        set_limits(2500, 40);
        idle_on = 1'b0;
        rx_hold_cycles = 400;
        for (int n = 0; n < 40; n++)
            send_random_beat(20, 5);
        drain_results();
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        err_cnt        = 0;
        rx_hold_cycles = 0;
        idle_on        = 1'b1;
        level_acc      = 0;
        lim_ma         = MAX_RESET;
        white_ma       = FW_RESET;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_ops();
        test_zero_full_white();
        test_zero_limit();
        test_random_traffic(65535, 255, 100, 1'b1);
        test_random_traffic(900, 60, 150, 1'b1);
        test_random_traffic(1, 255, 60, 1'b1);
        test_random_traffic($urandom_range(500, 20000), $urandom_range(1, 255), 150, 1'b0);
        test_output_stall();
        test_random_traffic(3000, 30, 150, 1'b1);
        test_random_traffic(20000, 255, 150, 1'b1);
        test_random_traffic(900, 60, 40, 1'b1);

        drain_results();
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/lfscl_pkg.sv
sv/lfscl_ram.sv
sv/led_frame_store_current_limiter.sv
dv/led_frame_store_current_limiter_tb.sv
